// ===== hw/rtl/i2cm_pkg.sv =====
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared types and constants for the command front end and the bus engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam int unsigned PhaseTicksReset = 8'd1;
  localparam int unsigned QueueDepth      = 2;

  typedef enum logic [1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_READ  = 2'd2,
    OP_DATA  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK   = 2'd0,
    STS_NACK = 2'd1,
    STS_ERR  = 2'd2
  } status_t;

  // One input transaction as it travels from the front end to the engine.
  typedef struct packed {
    op_t        op;
    logic [6:0] dev;
    logic [7:0] reg_addr;
    logic [7:0] count;
    logic [7:0] data;
    logic       sda;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic       scl;
    logic       sda;
    logic [7:0] rdata;
    logic       rvalid;
    logic       dreq;
    logic       busy;
    logic       done;
    status_t    status;
  } result_t;

endpackage

// ===== hw/rtl/i2cm_front.sv =====
// ----------------------------------------------------------------------------
// I2C master front end
// Accepts input transactions and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module i2cm_front #(
  parameter int unsigned DEPTH = i2cm_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  output logic            full,
  input  i2cm_pkg::item_t item_in,
  output logic            item_valid,
  input  logic            item_take,
  output i2cm_pkg::item_t item_out
);
  import i2cm_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  item_t           mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            do_push, do_pop;

  assign full       = (cnt_r == (AW+1)'(DEPTH));
  assign item_valid = (cnt_r != '0);
  assign item_out   = mem_r[rp_r];
  assign do_push    = push && !full;
  assign do_pop     = item_take && item_valid;

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + AW'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + (AW+1)'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - (AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= item_in;
    end
  end

endmodule

// ===== hw/rtl/i2cm_engine.sv =====
// ----------------------------------------------------------------------------
// I2C master bus engine
// Runs the bus state machine, one queued transaction per cycle while the
// two-entry output queue has room, and keeps results in that output queue.
// ----------------------------------------------------------------------------
module i2cm_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        phase_ticks,
  input  logic              item_valid,
  output logic              item_take,
  input  i2cm_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output i2cm_pkg::result_t res
);
  import i2cm_pkg::*;

  typedef enum logic [16:0] {
    S_IDLE    = 17'b1 << 0,  S_STA1   = 17'b1 << 1,  S_STA2   = 17'b1 << 2,
    S_SAW     = 17'b1 << 3,  S_AAW    = 17'b1 << 4,  S_SREG   = 17'b1 << 5,
    S_AREG    = 17'b1 << 6,  S_WAIT   = 17'b1 << 7,  S_SDAT   = 17'b1 << 8,
    S_ADAT    = 17'b1 << 9,  S_SAR    = 17'b1 << 10, S_AAR    = 17'b1 << 11,
    S_RBIT    = 17'b1 << 12, S_RACK   = 17'b1 << 13, S_STOK   = 17'b1 << 14,
    S_STNK    = 17'b1 << 15, S_STER   = 17'b1 << 16
  } state_t;

  state_t      st_r, st_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic [7:0]  tc_r, tc_nxt, tc_inc, limit;
  logic [2:0]  bi_r, bi_nxt;
  logic [7:0]  sh_r, sh_nxt, bl_r, bl_nxt, treg_r, treg_nxt;
  logic [6:0]  tadr_r, tadr_nxt;
  logic        rm_r, rm_nxt, scl_r, scl_nxt, sda_r, sda_nxt;
  logic        ev_v, ev_d;
  logic [7:0]  ev_data;
  status_t     ev_st;
  result_t     q_r [2];
  logic        qw_r, qr_r;
  logic [1:0]  qc_r;
  result_t     r_new;

  function automatic logic is_send(state_t s);
    return s == S_SAW || s == S_SREG || s == S_SDAT || s == S_SAR;
  endfunction
  function automatic logic is_wack(state_t s);
    return s == S_AAW || s == S_AREG || s == S_ADAT || s == S_AAR;
  endfunction
  function automatic logic is_stop(state_t s);
    return s == S_STOK || s == S_STNK || s == S_STER;
  endfunction

  assign item_take = item_valid && (qc_r != 2'd2);
  assign limit     = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
  assign tc_inc    = tc_r + 8'd1;

  always_comb begin
    logic       lv;
    logic [2:0] bi1;
    lv       = 1'b0;
    bi1      = bi_r + 3'd1;
    st_nxt   = st_r;
    ph_nxt   = ph_r;
    tc_nxt   = tc_r;
    bi_nxt   = bi_r;
    sh_nxt   = sh_r;
    bl_nxt   = bl_r;
    tadr_nxt = tadr_r;
    treg_nxt = treg_r;
    rm_nxt   = rm_r;
    ev_v     = 1'b0;
    ev_data  = 8'd0;
    ev_d     = 1'b0;
    ev_st    = STS_OK;
    // lv marks that line levels must be re-applied for (st_nxt, ph_nxt).
    if (item_take) begin
      unique case (item.op)
        OP_TICK: begin
          if (st_r != S_IDLE && st_r != S_WAIT) begin
            tc_nxt = tc_inc;
            if (tc_inc >= limit) begin
              tc_nxt = 8'd0;
              lv     = 1'b1;
              if (st_r == S_STA1 || st_r == S_STA2) begin
                if ((ph_r == 2'd0 && !item.sda) || (ph_r == 2'd1 && item.sda)) begin
                  st_nxt = S_STER; ph_nxt = 2'd0;
                end else if (ph_r < 2'd2) begin
                  ph_nxt = ph_r + 2'd1;
                end else begin
                  st_nxt = (st_r == S_STA1) ? S_SAW : S_SAR;
                  ph_nxt = 2'd0;
                  bi_nxt = 3'd0;
                  sh_nxt = {tadr_r, (st_r == S_STA2)};
                end
              end else if (is_send(st_r)) begin
                if (ph_r < 2'd2) begin
                  ph_nxt = ph_r + 2'd1;
                end else begin
                  sh_nxt = {sh_r[6:0], 1'b0};
                  bi_nxt = bi1;
                  ph_nxt = 2'd0;
                  if (bi1 == 3'd0) begin
                    unique case (st_r)
                      S_SAW:   st_nxt = S_AAW;
                      S_SREG:  st_nxt = S_AREG;
                      S_SDAT:  st_nxt = S_ADAT;
                      default: st_nxt = S_AAR;
                    endcase
                  end
                end
              end else if (is_wack(st_r)) begin
                if (ph_r == 2'd2 && st_r == S_AAW && item.sda) begin
                  st_nxt = S_STNK; ph_nxt = 2'd0;
                end else if (ph_r < 2'd3) begin
                  ph_nxt = ph_r + 2'd1;
                end else begin
                  ph_nxt = 2'd0;
                  if (st_r == S_AAW) begin
                    st_nxt = S_SREG; sh_nxt = treg_r; bi_nxt = 3'd0;
                  end else if (st_r == S_AREG && rm_r) begin
                    st_nxt = S_STA2;
                  end else if (st_r == S_AAR) begin
                    if (bl_r != 8'd0) begin
                      st_nxt = S_RBIT; bi_nxt = 3'd0; sh_nxt = 8'd0;
                    end else begin
                      st_nxt = S_STOK;
                    end
                  end else begin
                    st_nxt = (bl_r != 8'd0) ? S_WAIT : S_STOK;
                  end
                end
              end else if (st_r == S_RBIT) begin
                if (ph_r == 2'd0) begin
                  ph_nxt = 2'd1;
                end else begin
                  sh_nxt = {sh_r[6:0], item.sda};
                  bi_nxt = bi1;
                  ph_nxt = 2'd0;
                  if (bi1 == 3'd0) begin
                    bl_nxt  = bl_r - 8'd1;
                    ev_v    = 1'b1;
                    ev_data = {sh_r[6:0], item.sda};
                    st_nxt  = S_RACK;
                  end
                end
              end else if (st_r == S_RACK) begin
                if (ph_r < 2'd3) begin
                  ph_nxt = ph_r + 2'd1;
                end else begin
                  ph_nxt = 2'd0;
                  if (bl_r != 8'd0) begin
                    st_nxt = S_RBIT; bi_nxt = 3'd0; sh_nxt = 8'd0;
                  end else begin
                    st_nxt = S_STOK;
                  end
                end
              end else begin
                if (ph_r < 2'd3) begin
                  ph_nxt = ph_r + 2'd1;
                end else begin
                  lv     = 1'b0;
                  ev_d   = 1'b1;
                  ev_st  = (st_r == S_STOK) ? STS_OK :
                           (st_r == S_STNK) ? STS_NACK : STS_ERR;
                  st_nxt = S_IDLE;
                  ph_nxt = 2'd0;
                end
              end
            end
          end
        end
        OP_DATA: begin
          if (st_r == S_WAIT) begin
            bl_nxt = bl_r - 8'd1;
            sh_nxt = item.data;
            bi_nxt = 3'd0;
            st_nxt = S_SDAT;
            ph_nxt = 2'd0;
            tc_nxt = 8'd0;
            lv     = 1'b1;
          end
        end
        default: begin
          if (st_r == S_IDLE) begin
            tadr_nxt = item.dev;
            treg_nxt = item.reg_addr;
            bl_nxt   = item.count;
            rm_nxt   = (item.op == OP_READ);
            st_nxt   = S_STA1;
            ph_nxt   = 2'd0;
            tc_nxt   = 8'd0;
            lv       = 1'b1;
          end
        end
      endcase
    end
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    if (lv) begin
      if (st_nxt == S_STA1 || st_nxt == S_STA2) begin
        if (ph_nxt == 2'd0) begin
          scl_nxt = 1'b1; sda_nxt = 1'b1;
        end else begin
          sda_nxt = 1'b0;
        end
      end else if (is_send(st_nxt)) begin
        if (ph_nxt == 2'd0) scl_nxt = 1'b0;
        else if (ph_nxt == 2'd1) sda_nxt = sh_nxt[7];
        else scl_nxt = 1'b1;
      end else if (is_wack(st_nxt)) begin
        if (ph_nxt == 2'd1) sda_nxt = 1'b1;
        else scl_nxt = (ph_nxt == 2'd2);
      end else if (st_nxt == S_RBIT) begin
        if (ph_nxt == 2'd0) begin
          scl_nxt = 1'b0; sda_nxt = 1'b1;
        end else begin
          scl_nxt = 1'b1;
        end
      end else if (st_nxt == S_RACK) begin
        if (ph_nxt == 2'd1) sda_nxt = (bl_nxt == 8'd0);
        else scl_nxt = (ph_nxt == 2'd2);
      end else if (is_stop(st_nxt)) begin
        if (ph_nxt == 2'd0) scl_nxt = 1'b0;
        else if (ph_nxt == 2'd1) sda_nxt = 1'b0;
        else if (ph_nxt == 2'd2) scl_nxt = 1'b1;
        else sda_nxt = 1'b1;
      end
    end
    r_new = '{scl: scl_nxt, sda: sda_nxt, rdata: ev_data, rvalid: ev_v,
              dreq: (st_nxt == S_WAIT), busy: (st_nxt != S_IDLE),
              done: ev_d, status: ev_st};
  end

  assign empty = (qc_r == 2'd0);
  assign res   = q_r[qr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ph_r <= '0; tc_r <= '0; bi_r <= '0; sh_r <= '0;
      bl_r <= '0; tadr_r <= '0; treg_r <= '0; rm_r <= 1'b0;
      scl_r <= 1'b1; sda_r <= 1'b1;
      qw_r <= 1'b0; qr_r <= 1'b0; qc_r <= 2'd0;
    end else begin
      st_r <= st_nxt; ph_r <= ph_nxt; tc_r <= tc_nxt; bi_r <= bi_nxt;
      sh_r <= sh_nxt; bl_r <= bl_nxt; tadr_r <= tadr_nxt; treg_r <= treg_nxt;
      rm_r <= rm_nxt; scl_r <= scl_nxt; sda_r <= sda_nxt;
      if (item_take) qw_r <= ~qw_r;
      if (pop && !empty) qr_r <= ~qr_r;
      qc_r <= qc_r + 2'(item_take) - 2'(pop && !empty);
    end
  end

  always_ff @(posedge clk) begin
    if (item_take) q_r[qw_r] <= r_new;
  end

endmodule

// ===== hw/rtl/i2c_master_register_access_core.sv =====
// ----------------------------------------------------------------------------
// I2C master register access core
// Queue-style wrapper around the command front end and the bus engine.
// ----------------------------------------------------------------------------
// Usage: push a transaction on in_* while full is low; each one yields exactly
// one result transaction on out_*, read while empty is low and taken by pop.
// Tick transactions advance the bus by one tick; commands start a burst write
// or read; data transactions supply write bytes when out_data_request is set.
// Each accepted input passes through the input queue to the engine, which
// writes its result into the result queue; the block sustains one transaction per cycle while results are popped.
// When the receiver stalls, the two-entry result queue fills, the engine stops
// taking from the input queue, and full rises once that queue is also full.
// cfg_phase_ticks may be written through cfg_valid/cfg_ready while idle.
// Reset empties both queues, releases SCL and SDA and sets phase_ticks to 1.
// ----------------------------------------------------------------------------
module i2c_master_register_access_core #(
  parameter int unsigned QUEUE_DEPTH = i2cm_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [1:0] in_operation,
  input  logic [6:0] in_device_address,
  input  logic [7:0] in_register_address,
  input  logic [7:0] in_byte_count,
  input  logic [7:0] in_data_byte,
  input  logic       in_sda_sample,
  output logic       empty,
  input  logic       pop,
  output logic       out_scl_release,
  output logic       out_sda_release,
  output logic [7:0] out_read_data,
  output logic       out_read_valid,
  output logic       out_data_request,
  output logic       out_busy_res,
  output logic       out_done_res,
  output logic [1:0] out_status,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_phase_ticks
);
  import i2cm_pkg::*;

  logic [7:0] pt_r;
  item_t      it_in, it_q;
  logic       it_valid, it_take;
  result_t    res;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) pt_r <= 8'(PhaseTicksReset);
    else if (cfg_valid) pt_r <= cfg_phase_ticks;
  end

  assign it_in = '{op: op_t'(in_operation), dev: in_device_address,
                   reg_addr: in_register_address, count: in_byte_count,
                   data: in_data_byte, sda: in_sda_sample};

  i2cm_front #(.DEPTH(QUEUE_DEPTH)) u_front (
    .clk, .rst_n, .push, .full, .item_in(it_in),
    .item_valid(it_valid), .item_take(it_take), .item_out(it_q)
  );

  i2cm_engine u_engine (
    .clk, .rst_n, .phase_ticks(pt_r), .item_valid(it_valid),
    .item_take(it_take), .item(it_q), .empty, .pop, .res
  );

  assign out_scl_release  = res.scl;
  assign out_sda_release  = res.sda;
  assign out_read_data    = res.rdata;
  assign out_read_valid   = res.rvalid;
  assign out_data_request = res.dreq;
  assign out_busy_res     = res.busy;
  assign out_done_res     = res.done;
  assign out_status       = res.status;

endmodule
